>>> hdl/bsesc_pkg.sv
package bsesc_pkg;

    localparam int FRAC_BITS    = 26;
    localparam int WORD_W       = FRAC_BITS + 6;
    localparam int SUM_W        = WORD_W + 2;
    localparam int MUL_W        = 2 * WORD_W;
    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;
    localparam int PIX_W        = 10;
    localparam int DIFF_W       = 14;
    localparam int STEP_W       = 31;
    localparam int OFFSET_W     = 30;
    localparam int PROD_W       = DIFF_W + STEP_W + 1;
    localparam int ITER_W       = 16;
    localparam int CFG_DATA_W   = 31;
    localparam int CFG_INDEX_W  = 3;
    localparam int SLOT_W       = 3;
    localparam int NUM_SLOTS    = 1 << SLOT_W;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [WORD_W-1:0]        umag_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic [SLOT_W-1:0]        slot_t;
    typedef logic [ITER_W-1:0]        count_t;

    localparam diff_t HALF_W = DIFF_W'(IMAGE_WIDTH / 2);
    localparam diff_t HALF_H = DIFF_W'(IMAGE_HEIGHT / 2);

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t FOUR     = WORD_W'(4) << FRAC_BITS;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_ITER = 3'd0,
        CFG_STEP_X   = 3'd1,
        CFG_STEP_Y   = 3'd2,
        CFG_VIEW_RE  = 3'd3,
        CFG_VIEW_IM  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_col;
        logic [PIX_W-1:0] pixel_row;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_col;
        logic [PIX_W-1:0] out_row;
        count_t           escape_count;
    } out_word_t;

    typedef struct packed {
        count_t                      max_iterations;
        logic [STEP_W-1:0]           step_x;
        logic [STEP_W-1:0]           step_y;
        logic signed [OFFSET_W-1:0]  view_re;
        logic signed [OFFSET_W-1:0]  view_im;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_iterations: ITER_W'(256),
        step_x:         STEP_W'(196608),
        step_y:         STEP_W'(131072),
        view_re:        '0,
        view_im:        '0
    };

    // point handed from the mapper to the iteration ring
    typedef struct packed {
        slot_t slot;
        word_t cx;
        word_t cy;
    } ctx_t;

    // finished point leaving the ring
    typedef struct packed {
        logic   valid;
        slot_t  slot;
        count_t count;
    } fin_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rob_stat_t;

    function automatic word_t clamp_prod(input prod_t v);
        logic [PROD_W-WORD_W:0] hi;
        hi = v[PROD_W-1:WORD_W-1];
        if (hi == '0 || hi == '1)
            return word_t'(v[WORD_W-1:0]);
        else if (v[PROD_W-1])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

    function automatic word_t sat_sum(input sum_t v);
        logic [SUM_W-WORD_W:0] hi;
        hi = v[SUM_W-1:WORD_W-1];
        if (hi == '0 || hi == '1)
            return word_t'(v[WORD_W-1:0]);
        else if (v[SUM_W-1])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

    function automatic sum_t ext_sum(input word_t a);
        return $signed({{(SUM_W-WORD_W){a[WORD_W-1]}}, a});
    endfunction

    function automatic umag_t mag(input word_t a);
        umag_t u;
        u = umag_t'(a);
        return u[WORD_W-1] ? (~u + WORD_W'(1)) : u;
    endfunction

    function automatic word_t sabs(input word_t a);
        if (a == WORD_MIN)
            return WORD_MAX;
        else if (a[WORD_W-1])
            return -a;
        else
            return a;
    endfunction

    // truncate magnitude product to FRAC_BITS, saturate to WORD_MAX
    function automatic word_t mul_sat(input logic [MUL_W-1:0] p);
        logic over;
        over = |p[MUL_W-1:FRAC_BITS+WORD_W-1];
        return over ? WORD_MAX : word_t'({1'b0, p[FRAC_BITS+WORD_W-2:FRAC_BITS]});
    endfunction

endpackage

>>> hdl/bsesc_map.sv
module bsesc_map (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  bsesc_pkg::in_word_t pix,
    input  bsesc_pkg::slot_t    slot,
    input  bsesc_pkg::cfg_t     cfg,
    input  logic                inj_take,
    output logic                ready,
    output logic                inj_valid,
    output bsesc_pkg::ctx_t     inj_ctx
);

    logic               m1_valid_reg;
    logic               m2_valid_reg;
    bsesc_pkg::prod_t   px_reg;
    bsesc_pkg::prod_t   py_reg;
    bsesc_pkg::slot_t   m1_slot_reg;
    bsesc_pkg::ctx_t    m2_ctx_reg;

    bsesc_pkg::diff_t   dcol;
    bsesc_pkg::diff_t   drow;
    bsesc_pkg::prod_t   px_next;
    bsesc_pkg::prod_t   py_next;
    bsesc_pkg::ctx_t    m2_ctx_next;
    bsesc_pkg::sum_t    sx;
    bsesc_pkg::sum_t    sy;
    logic               m2_free;
    logic               m1_free;

    assign m2_free = !m2_valid_reg || inj_take;
    assign m1_free = !m1_valid_reg || m2_free;
    assign ready   = m1_free;

    always_comb
    begin
        dcol    = $signed({{(bsesc_pkg::DIFF_W-bsesc_pkg::PIX_W){1'b0}}, pix.pixel_col})
                  - bsesc_pkg::HALF_W;
        drow    = $signed({{(bsesc_pkg::DIFF_W-bsesc_pkg::PIX_W){1'b0}}, pix.pixel_row})
                  - bsesc_pkg::HALF_H;
        px_next = bsesc_pkg::prod_t'(dcol)
                  * bsesc_pkg::prod_t'($signed({1'b0, cfg.step_x}));
        py_next = bsesc_pkg::prod_t'(drow)
                  * bsesc_pkg::prod_t'($signed({1'b0, cfg.step_y}));
    end

    always_comb
    begin
        sx = bsesc_pkg::ext_sum(bsesc_pkg::clamp_prod(px_reg))
             + bsesc_pkg::sum_t'(cfg.view_re);
        sy = bsesc_pkg::ext_sum(bsesc_pkg::clamp_prod(py_reg))
             + bsesc_pkg::sum_t'(cfg.view_im);
        m2_ctx_next.slot = m1_slot_reg;
        m2_ctx_next.cx   = bsesc_pkg::sat_sum(sx);
        m2_ctx_next.cy   = bsesc_pkg::sat_sum(sy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            if (m1_free)
                m1_valid_reg <= take;
            if (m2_free)
                m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m1_free && take)
        begin
            px_reg      <= px_next;
            py_reg      <= py_next;
            m1_slot_reg <= slot;
        end
        if (m2_free && m1_valid_reg)
            m2_ctx_reg <= m2_ctx_next;
    end

    assign inj_valid = m2_valid_reg;
    assign inj_ctx   = m2_ctx_reg;

endmodule

>>> hdl/bsesc_iter.sv
module bsesc_iter (
    input  logic              clk,
    input  logic              rst_n,
    input  bsesc_pkg::count_t max_iterations,
    input  logic              inj_valid,
    input  bsesc_pkg::ctx_t   inj_ctx,
    output logic              inj_take,
    output bsesc_pkg::fin_t   fin
);

    typedef struct packed {
        bsesc_pkg::slot_t  slot;
        bsesc_pkg::word_t  cx;
        bsesc_pkg::word_t  cy;
        bsesc_pkg::count_t iter;
    } ring_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    ring_t c1_reg, c2_reg, c3_reg, c4_reg;

    bsesc_pkg::umag_t             mx_reg, my_reg;
    logic [bsesc_pkg::MUL_W-1:0]  pxx_reg, pyy_reg, pxy_reg;
    bsesc_pkg::word_t             diff_reg, dxy_reg;
    logic                         done3_reg;
    bsesc_pkg::word_t             x4_reg, y4_reg;
    logic                         done4_reg;

    logic                         recirc;
    logic                         v1_next;
    ring_t                        c1_next;
    bsesc_pkg::word_t             x_in, y_in;

    bsesc_pkg::word_t             x2, y2, xy;
    logic [bsesc_pkg::WORD_W:0]   mag_sum;
    bsesc_pkg::word_t             diff_next, dxy_next;
    logic                         done3_next;

    bsesc_pkg::word_t             x4_next, y4_next;
    bsesc_pkg::count_t            iter4_next;
    ring_t                        c4_next;

    // the slot at the ring head opens when it is empty or its point has finished
    assign recirc   = v4_reg && !done4_reg;
    assign inj_take = inj_valid && !recirc;
    assign v1_next  = recirc || inj_take;

    always_comb
    begin
        if (recirc)
        begin
            c1_next = c4_reg;
            x_in    = x4_reg;
            y_in    = y4_reg;
        end
        else
        begin
            c1_next.slot = inj_ctx.slot;
            c1_next.cx   = inj_ctx.cx;
            c1_next.cy   = inj_ctx.cy;
            c1_next.iter = '0;
            x_in         = '0;
            y_in         = '0;
        end
    end

    // products in pxx/pyy/pxy line up with c2
    always_comb
    begin
        x2         = bsesc_pkg::mul_sat(pxx_reg);
        y2         = bsesc_pkg::mul_sat(pyy_reg);
        xy         = bsesc_pkg::mul_sat(pxy_reg);
        mag_sum    = {1'b0, x2} + {1'b0, y2};
        done3_next = (mag_sum > {1'b0, bsesc_pkg::FOUR}) || (c2_reg.iter >= max_iterations);
        diff_next  = x2 - y2;
        // 2xy overflows once xy reaches a quarter of the range
        dxy_next   = xy[bsesc_pkg::WORD_W-2] ? bsesc_pkg::WORD_MAX
                                             : {xy[bsesc_pkg::WORD_W-2:0], 1'b0};
    end

    always_comb
    begin
        x4_next      = bsesc_pkg::sabs(bsesc_pkg::sat_sum(
                           bsesc_pkg::ext_sum(diff_reg) + bsesc_pkg::ext_sum(c3_reg.cx)));
        y4_next      = bsesc_pkg::sat_sum(
                           bsesc_pkg::ext_sum(dxy_reg) + bsesc_pkg::ext_sum(c3_reg.cy));
        iter4_next   = done3_reg ? c3_reg.iter : c3_reg.iter + bsesc_pkg::ITER_W'(1);
        c4_next      = c3_reg;
        c4_next.iter = iter4_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg    <= c1_next;
        mx_reg    <= bsesc_pkg::mag(x_in);
        my_reg    <= bsesc_pkg::mag(y_in);

        c2_reg    <= c1_reg;
        pxx_reg   <= bsesc_pkg::MUL_W'(mx_reg) * bsesc_pkg::MUL_W'(mx_reg);
        pyy_reg   <= bsesc_pkg::MUL_W'(my_reg) * bsesc_pkg::MUL_W'(my_reg);
        pxy_reg   <= bsesc_pkg::MUL_W'(mx_reg) * bsesc_pkg::MUL_W'(my_reg);

        c3_reg    <= c2_reg;
        diff_reg  <= diff_next;
        dxy_reg   <= dxy_next;
        done3_reg <= done3_next;

        c4_reg    <= c4_next;
        x4_reg    <= x4_next;
        y4_reg    <= y4_next;
        done4_reg <= done3_reg;
    end

    assign fin.valid = v4_reg && done4_reg;
    assign fin.slot  = c4_reg.slot;
    assign fin.count = c4_reg.iter;

endmodule

>>> hdl/bsesc_rob.sv
module bsesc_rob (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  bsesc_pkg::in_word_t  pix,
    input  bsesc_pkg::fin_t      fin,
    input  logic                 out_stall,
    output bsesc_pkg::slot_t     tail,
    output bsesc_pkg::rob_stat_t stat,
    output logic                 out_valid,
    output bsesc_pkg::out_word_t out_data
);

    logic [bsesc_pkg::PIX_W-1:0]   col_reg [bsesc_pkg::NUM_SLOTS];
    logic [bsesc_pkg::PIX_W-1:0]   row_reg [bsesc_pkg::NUM_SLOTS];
    bsesc_pkg::count_t             cnt_reg [bsesc_pkg::NUM_SLOTS];
    logic [bsesc_pkg::NUM_SLOTS-1:0] ready_reg;
    logic [bsesc_pkg::NUM_SLOTS-1:0] ready_next;
    bsesc_pkg::slot_t              head_reg, tail_reg;
    logic [bsesc_pkg::SLOT_W:0]    used_reg, used_next;
    logic                          out_take;

    // words leave in the order their slots were handed out
    assign out_valid = ready_reg[head_reg];
    assign out_take  = out_valid && !out_stall;
    assign out_data.out_col      = col_reg[head_reg];
    assign out_data.out_row      = row_reg[head_reg];
    assign out_data.escape_count = cnt_reg[head_reg];

    assign tail       = tail_reg;
    assign stat.full  = (used_reg == (bsesc_pkg::SLOT_W+1)'(bsesc_pkg::NUM_SLOTS));
    assign stat.empty = (used_reg == '0);

    always_comb
    begin
        ready_next = ready_reg;
        if (out_take)
            ready_next[head_reg] = 1'b0;
        if (fin.valid)
            ready_next[fin.slot] = 1'b1;

        case ({take, out_take})
            2'b10:   used_next = used_reg + (bsesc_pkg::SLOT_W+1)'(1);
            2'b01:   used_next = used_reg - (bsesc_pkg::SLOT_W+1)'(1);
            default: used_next = used_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            ready_reg <= ready_next;
            used_reg  <= used_next;
            if (take)
                tail_reg <= tail_reg + bsesc_pkg::SLOT_W'(1);
            if (out_take)
                head_reg <= head_reg + bsesc_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            col_reg[tail_reg] <= pix.pixel_col;
            row_reg[tail_reg] <= pix.pixel_row;
        end
        if (fin.valid)
            cnt_reg[fin.slot] <= fin.count;
    end

endmodule

>>> hdl/burning_ship_escape_time_top.sv
// Path: an accepted word passes the mapper registers, circles the iteration ring once per
// iteration and once more to stop, and is marked ready in its result slot, after any wait for a
// free ring slot or for earlier words to drain. Throughput: the four-stage iteration ring holds
// four points, so one word a cycle when points stop at once and no stall or full slot set holds it.
// Eight result slots keep words in arrival order.
// Reset: clears all valid bits, slot pointers and loads the registers' reset values.
module burning_ship_escape_time_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  bsesc_pkg::in_word_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output bsesc_pkg::out_word_t                  out_data,
    input  logic                                  cfg_wr_en,
    input  logic [bsesc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bsesc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    bsesc_pkg::cfg_t      cfg_reg, cfg_next;
    logic                 in_take;
    logic                 map_ready;
    logic                 inj_valid;
    logic                 inj_take;
    bsesc_pkg::ctx_t      inj_ctx;
    bsesc_pkg::fin_t      fin;
    bsesc_pkg::slot_t     tail;
    bsesc_pkg::rob_stat_t stat;

    assign in_stall = !map_ready || stat.full;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (bsesc_pkg::cfg_idx_t'(cfg_index))
                bsesc_pkg::CFG_MAX_ITER: cfg_next.max_iterations = cfg_data[bsesc_pkg::ITER_W-1:0];
                bsesc_pkg::CFG_STEP_X:   cfg_next.step_x  = cfg_data[bsesc_pkg::STEP_W-1:0];
                bsesc_pkg::CFG_STEP_Y:   cfg_next.step_y  = cfg_data[bsesc_pkg::STEP_W-1:0];
                bsesc_pkg::CFG_VIEW_RE:  cfg_next.view_re = cfg_data[bsesc_pkg::OFFSET_W-1:0];
                bsesc_pkg::CFG_VIEW_IM:  cfg_next.view_im = cfg_data[bsesc_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= bsesc_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    bsesc_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .pix       (in_data),
        .slot      (tail),
        .cfg       (cfg_reg),
        .inj_take  (inj_take),
        .ready     (map_ready),
        .inj_valid (inj_valid),
        .inj_ctx   (inj_ctx)
    );

    bsesc_iter u_iter (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_iterations (cfg_reg.max_iterations),
        .inj_valid      (inj_valid),
        .inj_ctx        (inj_ctx),
        .inj_take       (inj_take),
        .fin            (fin)
    );

    bsesc_rob u_rob (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .pix       (in_data),
        .fin       (fin),
        .out_stall (out_stall),
        .tail      (tail),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    a_out_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !stat.empty)
        else $error("output word with no slot in use");

    a_fin_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |-> !stat.empty)
        else $error("point finished with no slot in use");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !(out_valid && !out_stall)) |=> !stat.empty)
        else $error("accepted word left no slot in use");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> in_stall)
        else $error("input not stalled with all slots in use");

endmodule

>>> tb/sv/bsesc_checker.sv
module bsesc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  bsesc_pkg::in_word_t               in_data,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  bsesc_pkg::out_word_t              out_data,
    input  logic                              cfg_wr_en,
    input  logic [bsesc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsesc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                pending,
    output int                                errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FB       = bsesc_pkg::FRAC_BITS;
    localparam longint W_MAX    = (longint'(1) << (FB + 5)) - 1;
    localparam longint W_MIN    = -W_MAX - 1;
    localparam longint BAILOUT  = longint'(4) << FB;
    localparam longint HALF_COL = bsesc_pkg::IMAGE_WIDTH / 2;
    localparam longint HALF_ROW = bsesc_pkg::IMAGE_HEIGHT / 2;

    logic [15:0]        iter_limit;
    logic [30:0]        step_col;
    logic [30:0]        step_row;
    logic signed [29:0] centre_x;
    logic signed [29:0] centre_y;

    bsesc_pkg::out_word_t counts_due[$];
    int                   fails;

    function automatic longint clamp_word(input longint v);
        if (v > W_MAX)
            return W_MAX;
        if (v < W_MIN)
            return W_MIN;
        return v;
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint abs_sat(input longint a);
        return clamp_word(a < 0 ? -a : a);
    endfunction

    // |a|*|b| truncated at the binary point; magnitudes are at most 2^31 so 64 bits hold it
    function automatic longint mul_mag(input longint a, input longint b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] prod;
        ma   = a < 0 ? -a : a;
        mb   = b < 0 ? -b : b;
        prod = (ma * mb) >> FB;
        if (prod > 64'(W_MAX))
            return W_MAX;
        return longint'(prod);
    endfunction

    function automatic longint map_axis(input logic [9:0] pix, input longint half,
                                        input logic [30:0] step,
                                        input logic signed [29:0] centre);
        longint d;
        d = longint'(pix) - half;
        return add_sat(clamp_word(d * longint'(step)), clamp_word(longint'(centre)));
    endfunction

    function automatic int escape_count_at(input logic [9:0] col, input logic [9:0] row);
        longint cx;
        longint cy;
        longint x;
        longint y;
        longint x2;
        longint y2;
        longint xy;
        int     n;
        cx = map_axis(col, HALF_COL, step_col, centre_x);
        cy = map_axis(row, HALF_ROW, step_row, centre_y);
        x  = 0;
        y  = 0;
        n  = 0;
        forever
        begin
            x2 = mul_mag(x, x);
            y2 = mul_mag(y, y);
            if (add_sat(x2, y2) > BAILOUT || n >= int'(iter_limit))
                break;
            xy = mul_mag(x, y);
            x  = abs_sat(add_sat(add_sat(x2, -y2), cx));
            y  = add_sat(add_sat(xy, xy), cy);
            n++;
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bsesc_pkg::out_word_t want;
        if (!rst_n)
        begin
            iter_limit = 16'd256;
            step_col   = 31'd196608;
            step_row   = 31'd131072;
            centre_x   = '0;
            centre_y   = '0;
            counts_due.delete();
            fails      = 0;
            pending   <= 0;
            errors    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (bsesc_pkg::cfg_idx_t'(cfg_index))
                    bsesc_pkg::CFG_MAX_ITER: iter_limit = cfg_data[15:0];
                    bsesc_pkg::CFG_STEP_X:   step_col   = cfg_data[30:0];
                    bsesc_pkg::CFG_STEP_Y:   step_row   = cfg_data[30:0];
                    bsesc_pkg::CFG_VIEW_RE:  centre_x   = cfg_data[29:0];
                    bsesc_pkg::CFG_VIEW_IM:  centre_y   = cfg_data[29:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (counts_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%t: unexpected word col %0d row %0d count %0d", $realtime,
                                 out_data.out_col, out_data.out_row, out_data.escape_count);
                end
                else
                begin
                    want = counts_due.pop_front();
                    if (out_data.out_col !== want.out_col || out_data.out_row !== want.out_row
                        || out_data.escape_count !== want.escape_count)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"%t: mismatch col/row/count expected %0d/%0d/%0d",
                                      " got %0d/%0d/%0d"},
                                     $realtime, want.out_col, want.out_row, want.escape_count,
                                     out_data.out_col, out_data.out_row, out_data.escape_count);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                want.out_col      = in_data.pixel_col;
                want.out_row      = in_data.pixel_row;
                want.escape_count = bsesc_pkg::count_t'(escape_count_at(in_data.pixel_col,
                                                                        in_data.pixel_row));
                counts_due.push_back(want);
            end

            pending <= counts_due.size();
            errors  <= fails;
        end
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [30:0] STEP_COL_DEF = 31'd196608;
    localparam logic [30:0] STEP_ROW_DEF = 31'd131072;
    localparam logic [30:0] STEP_TOP     = 31'h7FFF_FFFF;
    localparam int          OFF_LO       = -(1 << 29);
    localparam int          OFF_HI       = (1 << 29) - 1;
    localparam int          FOUR_UNITS   = 1 << 28;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    bsesc_pkg::in_word_t               in_data;
    logic                              out_valid;
    logic                              out_stall;
    bsesc_pkg::out_word_t              out_data;
    logic                              cfg_wr_en;
    logic [bsesc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bsesc_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                                pending;
    int                                errors;

    bit                                quiet;
    logic [15:0]                       lim;
    logic [30:0]                       sx;
    logic [30:0]                       sy;
    int                                ox;
    int                                oy;

    burning_ship_escape_time_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bsesc_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver stalls at random except during the quiet stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= !quiet && ($urandom_range(99) < 22);
        end
    end

    task automatic write_reg(input bsesc_pkg::cfg_idx_t idx,
                             input logic [bsesc_pkg::CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic set_view(input logic [15:0] iters, input logic [30:0] scol,
                            input logic [30:0] srow, input int cx, input int cy);
        write_reg(bsesc_pkg::CFG_MAX_ITER, bsesc_pkg::CFG_DATA_W'(iters));
        write_reg(bsesc_pkg::CFG_STEP_X, bsesc_pkg::CFG_DATA_W'(scol));
        write_reg(bsesc_pkg::CFG_STEP_Y, bsesc_pkg::CFG_DATA_W'(srow));
        write_reg(bsesc_pkg::CFG_VIEW_RE, bsesc_pkg::CFG_DATA_W'(cx));
        write_reg(bsesc_pkg::CFG_VIEW_IM, bsesc_pkg::CFG_DATA_W'(cy));
        cfg_wr_en <= 1'b0;
    endtask

    // returns at the edge that takes the word, valid still high
    task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
        if (!quiet && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 22);
        end
        in_valid <= 1'b1;
        in_data  <= '{pixel_col: col, pixel_row: row};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // pending is registered, and the first sample already covers the last word taken
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: corners, centre, alternating bit patterns
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd511, 10'd511);
        send_pixel(10'h155, 10'h2AA);
        send_pixel(10'h2AA, 10'h155);
        drain();

        // zero limit: no iteration at all
        set_view(16'd0, STEP_COL_DEF, STEP_ROW_DEF, 0, 0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain();

        // widest step and most negative centre: coordinates saturate, |min word| clips
        set_view(16'd300, STEP_TOP, STEP_TOP, OFF_LO, OFF_LO);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd512);
        drain();

        set_view(16'd20, 31'd1, 31'd1, OFF_HI, OFF_HI);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        drain();

        set_view(16'd20, 31'd1, 31'd1, -FOUR_UNITS, FOUR_UNITS);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain();

        // full limit: the origin never escapes
        set_view(16'hFFFF, STEP_COL_DEF, STEP_ROW_DEF, 0, 0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd100, 10'd900);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            lim = ($urandom_range(3) == 0) ? 16'($urandom_range(65, 300))
                                           : 16'($urandom_range(1, 64));
            sx  = ($urandom_range(9) == 0) ? 31'($urandom_range(1, 32'h7FFF_FFFF))
                                           : STEP_COL_DEF >> $urandom_range(0, 10);
            sy  = ($urandom_range(9) == 0) ? 31'($urandom_range(1, 32'h7FFF_FFFF))
                                           : STEP_ROW_DEF >> $urandom_range(0, 10);
            if ($urandom_range(7) == 0)
            begin
                ox = int'($urandom_range(0, 2 * FOUR_UNITS)) - FOUR_UNITS;
                oy = int'($urandom_range(0, 2 * FOUR_UNITS)) - FOUR_UNITS;
            end
            else
            begin
                // mostly around the ship itself
                ox = int'($urandom_range(0, FOUR_UNITS)) - FOUR_UNITS / 2;
                oy = int'($urandom_range(0, FOUR_UNITS)) - FOUR_UNITS / 2;
            end
            set_view(lim, sx, sy, ox, oy);
            quiet = (ph == 4);
            repeat ($urandom_range(120, 180))
                send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
            drain();
        end
        quiet = 1'b0;

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
